// File: rtl/core/sfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfs_pkg;

	// field widths
	localparam int DUR_W   = 32;
	localparam int CELL_W  = 12;
	localparam int COORD_W = 16;
	localparam int FC_W    = 5;
	localparam int LIN_W   = CELL_W + COORD_W;          // cell * step_x
	localparam int PROD_W  = LIN_W + COORD_W;           // step_y * row
	localparam int TOTAL_W = DUR_W + FC_W;              // sum of up to 31 durations
	localparam int DVD_W   = DUR_W;                     // divider dividend
	localparam int DVS_W   = TOTAL_W;                   // divider divisor
	localparam int STEP_W  = $clog2(DVD_W + 1);
	localparam int CIDX_W  = 3;

	// operation codes
	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_PLAY  = 3'd1;
	localparam logic [2:0] OP_PAUSE = 3'd2;
	localparam logic [2:0] OP_STOP  = 3'd3;
	localparam logic [2:0] OP_SEEK  = 3'd4;
	localparam logic [2:0] OP_LOAD  = 3'd5;

	// run state codes
	localparam logic [1:0] PS_PLAYING = 2'd0;
	localparam logic [1:0] PS_PAUSED  = 2'd1;
	localparam logic [1:0] PS_STOPPED = 2'd2;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_SHEET_SPAN  = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_ORIGIN_X    = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_ORIGIN_Y    = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_STEP_X      = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_STEP_Y      = 3'd4;
	localparam logic [CIDX_W-1:0] CFG_FRAME_COUNT = 3'd5;
	localparam logic [CIDX_W-1:0] CFG_LOOP_ENABLE = 3'd6;

	typedef struct packed {
		logic [2:0]        operation;
		logic [DUR_W-1:0]  delta;
		logic [7:0]        slot;
		logic [DUR_W-1:0]  duration;
		logic [CELL_W-1:0] cell_req;
	} item_t;

	typedef struct packed {
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] top;
		logic [3:0]         frame_now;
		logic [1:0]         play_status;
	} result_t;

	typedef struct packed {
		logic [COORD_W-1:0] sheet_span;
		logic [COORD_W-1:0] origin_x;
		logic [COORD_W-1:0] origin_y;
		logic [COORD_W-1:0] step_x;
		logic [COORD_W-1:0] step_y;
		logic [FC_W-1:0]    frame_count;
		logic               loop_enable;
	} cfg_t;

	typedef enum logic [1:0] {
		DIV_SEEK,
		DIV_MOD,
		DIV_RECT
	} div_sel_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SEEK_WAIT,
		ST_TICK_START,
		ST_FRAME_RD,
		ST_FRAME_CHK,
		ST_SUM,
		ST_SUM_TAIL,
		ST_MOD_CHK,
		ST_MOD_WAIT,
		ST_CELL_RD,
		ST_LIN,
		ST_RECT_DIV,
		ST_RECT_WAIT,
		ST_TOP,
		ST_RECT_FIN,
		ST_DONE
	} ctrl_st_t;

	typedef struct packed {
		logic     latch_in;
		logic     do_simple;
		logic     div_start;
		div_sel_t div_sel;
		logic     seek_apply;
		logic     tick_start;
		logic     rd_en;
		logic     rd_sum;
		logic     advance;
		logic     sum_clear;
		logic     sum_issue;
		logic     mod_apply;
		logic     lin_load;
		logic     top_load;
		logic     rect_load;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       playing;
		logic       e_le_d;
		logic       need_reduce;
		logic       adv_stop;
		logic       sum_last;
		logic       e_gt_total;
		logic       div_busy;
	} stat_t;

endpackage

`default_nettype wire

// File: rtl/core/sfs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/sfs_div.sv
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle
module sfs_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [sfs_pkg::DVD_W-1:0] dividend,
	input  wire logic [sfs_pkg::DVS_W-1:0] divisor,
	output logic                           busy,
	output logic      [sfs_pkg::DVD_W-1:0] quotient,
	output logic      [sfs_pkg::DVS_W-1:0] remainder
);

	logic [sfs_pkg::DVS_W-1:0]  rem_q;
	logic [sfs_pkg::DVD_W-1:0]  quo_q;
	logic [sfs_pkg::DVS_W-1:0]  dvs_q;
	logic [sfs_pkg::STEP_W-1:0] step_q;
	logic                       busy_q;
	logic [sfs_pkg::DVS_W:0]    shifted;
	logic [sfs_pkg::DVS_W:0]    diff;
	logic                       ge;

	assign shifted = {rem_q, quo_q[sfs_pkg::DVD_W-1]};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= sfs_pkg::STEP_W'(sfs_pkg::DVD_W);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			busy_q <= (step_q != sfs_pkg::STEP_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[sfs_pkg::DVS_W-1:0] : shifted[sfs_pkg::DVS_W-1:0];
			quo_q <= {quo_q[sfs_pkg::DVD_W-2:0], ge};
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// File: rtl/core/sfs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module sfs_datapath #(
	parameter int MAX_FRAMES = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sfs_pkg::cfg_t    cfg,
	input  wire sfs_pkg::item_t   item,
	input  wire sfs_pkg::cmd_t    cmd,
	output sfs_pkg::stat_t        stat,
	output sfs_pkg::result_t      result
);

	localparam int FIDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CNTW   = ((FIDX_W > sfs_pkg::FC_W) ? FIDX_W : sfs_pkg::FC_W) + 1;
	localparam int RAM_W  = sfs_pkg::DUR_W + sfs_pkg::CELL_W;

	sfs_pkg::item_t                 in_q;
	logic [sfs_pkg::DUR_W-1:0]      e_q;
	logic [FIDX_W-1:0]              cur_q;
	logic [1:0]                     run_q;
	logic [sfs_pkg::COORD_W-1:0]    left_q;
	logic [sfs_pkg::COORD_W-1:0]    top_q;
	logic [MAX_FRAMES-1:0]          valid_q;
	logic                           reduced_q;
	logic [CNTW-1:0]                sum_idx_q;
	logic [sfs_pkg::TOTAL_W-1:0]    total_q;
	logic                           pend_s1;
	logic                           rd_valid_s1;
	logic [sfs_pkg::LIN_W-1:0]      lin_q;
	logic [sfs_pkg::PROD_W-1:0]     prod_q;
	sfs_pkg::result_t               res_q;

	logic [CNTW-1:0]                cnt;
	logic [CNTW-1:0]                cur_ext;
	logic [CNTW-1:0]                cur_nx;
	logic                           wrap;
	logic [sfs_pkg::COORD_W-1:0]    span;
	logic [sfs_pkg::DUR_W:0]        e_sum;
	logic [sfs_pkg::DUR_W-1:0]      e_sat;
	logic [RAM_W-1:0]               rd_data;
	logic [sfs_pkg::DUR_W-1:0]      dur_raw;
	logic [sfs_pkg::DUR_W-1:0]      dur;
	logic [sfs_pkg::CELL_W-1:0]     cell_rd;
	logic                           slot_ok;
	logic                           wr_en;
	logic [FIDX_W-1:0]              wr_addr;
	logic [FIDX_W-1:0]              rd_addr;
	logic [sfs_pkg::DVD_W-1:0]      div_dvd;
	logic [sfs_pkg::DVS_W-1:0]      div_dvs;
	logic                           div_busy;
	logic [sfs_pkg::DVD_W-1:0]      quo;
	logic [sfs_pkg::DVS_W-1:0]      rem;
	logic [sfs_pkg::COORD_W:0]      left_sum;
	logic [sfs_pkg::PROD_W:0]       top_sum;

	// frame count clamped to 1..MAX_FRAMES
	always_comb begin
		if (cfg.frame_count == '0) begin
			cnt = CNTW'(1);
		end else if (CNTW'(cfg.frame_count) > CNTW'(MAX_FRAMES)) begin
			cnt = CNTW'(MAX_FRAMES);
		end else begin
			cnt = CNTW'(cfg.frame_count);
		end
	end

	assign cur_ext = CNTW'(cur_q);
	assign cur_nx  = cur_ext + 1'b1;
	assign wrap    = cur_nx >= cnt;
	assign span    = (cfg.sheet_span == '0) ? sfs_pkg::COORD_W'(1) : cfg.sheet_span;

	assign e_sum = {1'b0, e_q} + {1'b0, in_q.delta};
	assign e_sat = e_sum[sfs_pkg::DUR_W] ? '1 : e_sum[sfs_pkg::DUR_W-1:0];

	// frame slot store; entries never loaded read as zero
	assign slot_ok = 32'(in_q.slot) < 32'(MAX_FRAMES);
	assign wr_en   = cmd.do_simple && (in_q.operation == sfs_pkg::OP_LOAD) && slot_ok;
	assign wr_addr = in_q.slot[FIDX_W-1:0];
	assign rd_addr = cmd.rd_sum ? sum_idx_q[FIDX_W-1:0] : cur_q;

	sfs_ram #(
		.WIDTH(RAM_W),
		.DEPTH(MAX_FRAMES)
	) u_slot_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data({in_q.duration, in_q.cell_req}),
		.rd_en  (cmd.rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign dur_raw = rd_valid_s1 ? rd_data[RAM_W-1:sfs_pkg::CELL_W] : '0;
	assign dur     = (dur_raw == '0) ? sfs_pkg::DUR_W'(1) : dur_raw;
	assign cell_rd = rd_valid_s1 ? rd_data[sfs_pkg::CELL_W-1:0] : '0;

	always_comb begin
		case (cmd.div_sel)
			sfs_pkg::DIV_MOD: begin
				div_dvd = e_q - 1'b1;
				div_dvs = total_q;
			end
			sfs_pkg::DIV_RECT: begin
				div_dvd = sfs_pkg::DVD_W'(lin_q);
				div_dvs = sfs_pkg::DVS_W'(span);
			end
			default: begin
				div_dvd = sfs_pkg::DVD_W'(in_q.slot);
				div_dvs = sfs_pkg::DVS_W'(cnt);
			end
		endcase
	end

	sfs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.quotient (quo),
		.remainder(rem)
	);

	assign left_sum = {1'b0, rem[sfs_pkg::COORD_W-1:0]} + {1'b0, cfg.origin_x};
	assign top_sum  = {1'b0, prod_q} + (sfs_pkg::PROD_W + 1)'(cfg.origin_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q         <= '0;
			cur_q       <= '0;
			run_q       <= sfs_pkg::PS_PLAYING;
			left_q      <= '0;
			top_q       <= '0;
			valid_q     <= '0;
			reduced_q   <= 1'b0;
			sum_idx_q   <= '0;
			total_q     <= '0;
			pend_s1     <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			pend_s1 <= cmd.sum_issue;
			if (cmd.rd_en) begin
				rd_valid_s1 <= valid_q[rd_addr];
			end
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (cmd.do_simple) begin
				case (in_q.operation)
					sfs_pkg::OP_PLAY:  run_q <= sfs_pkg::PS_PLAYING;
					sfs_pkg::OP_PAUSE: run_q <= sfs_pkg::PS_PAUSED;
					sfs_pkg::OP_STOP: begin
						run_q <= sfs_pkg::PS_STOPPED;
						cur_q <= '0;
					end
					default: ;
				endcase
			end
			if (cmd.seek_apply) begin
				cur_q <= rem[FIDX_W-1:0];
				e_q   <= '0;
			end
			if (cmd.tick_start) begin
				// count may have been lowered under the current frame
				if (cur_ext >= cnt) begin
					cur_q <= '0;
				end
				e_q       <= e_sat;
				reduced_q <= 1'b0;
			end
			if (cmd.advance) begin
				e_q <= e_q - dur;
				if (!wrap) begin
					cur_q <= cur_nx[FIDX_W-1:0];
				end else if (cfg.loop_enable) begin
					cur_q <= '0;
				end else begin
					run_q <= sfs_pkg::PS_STOPPED;
				end
			end
			if (cmd.sum_clear) begin
				sum_idx_q <= '0;
				total_q   <= '0;
				reduced_q <= 1'b1;
			end else begin
				if (cmd.sum_issue) begin
					sum_idx_q <= sum_idx_q + 1'b1;
				end
				if (pend_s1) begin
					total_q <= total_q + sfs_pkg::TOTAL_W'(dur);
				end
			end
			if (cmd.mod_apply) begin
				// (e-1) mod total + 1: whole passes of the loop removed
				e_q <= rem[sfs_pkg::DUR_W-1:0] + 1'b1;
			end
			if (cmd.rect_load) begin
				left_q <= left_sum[sfs_pkg::COORD_W] ? '1 : left_sum[sfs_pkg::COORD_W-1:0];
				top_q  <= (top_sum[sfs_pkg::PROD_W:sfs_pkg::COORD_W] != '0) ? '1
				          : top_sum[sfs_pkg::COORD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			in_q <= item;
		end
		if (cmd.lin_load) begin
			lin_q <= sfs_pkg::LIN_W'(cell_rd) * sfs_pkg::LIN_W'(cfg.step_x);
		end
		if (cmd.top_load) begin
			prod_q <= sfs_pkg::PROD_W'(cfg.step_y) * sfs_pkg::PROD_W'(quo[sfs_pkg::LIN_W-1:0]);
		end
		if (cmd.out_load) begin
			res_q.left        <= left_q;
			res_q.top         <= top_q;
			res_q.frame_now   <= cur_ext[3:0];
			res_q.play_status <= run_q;
		end
	end

	assign stat.op          = in_q.operation;
	assign stat.playing     = run_q == sfs_pkg::PS_PLAYING;
	assign stat.e_le_d      = e_q <= dur;
	assign stat.need_reduce = (cur_q == '0) && cfg.loop_enable && !reduced_q;
	assign stat.adv_stop    = wrap && !cfg.loop_enable;
	assign stat.sum_last    = sum_idx_q == (cnt - 1'b1);
	assign stat.e_gt_total  = sfs_pkg::TOTAL_W'(e_q) > total_q;
	assign stat.div_busy    = div_busy;

	assign result = res_q;

endmodule

`default_nettype wire

// File: rtl/core/sfs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sfs_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           item_valid,
	output logic                item_ready,
	output logic                result_valid,
	input  wire logic           result_ready,
	input  wire sfs_pkg::stat_t stat,
	output sfs_pkg::cmd_t       cmd
);

	sfs_pkg::ctrl_st_t state_q;
	sfs_pkg::ctrl_st_t state_nx;
	logic              out_valid_q;
	logic              out_free;
	logic              accept;

	assign out_free = !out_valid_q || result_ready;
	assign accept   = item_valid && (state_q == sfs_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sfs_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			sfs_pkg::ST_IDLE: begin
				if (accept) state_nx = sfs_pkg::ST_DECODE;
			end
			sfs_pkg::ST_DECODE: begin
				if (stat.op == sfs_pkg::OP_SEEK) begin
					state_nx = sfs_pkg::ST_SEEK_WAIT;
				end else if (stat.op == sfs_pkg::OP_TICK && stat.playing) begin
					state_nx = sfs_pkg::ST_TICK_START;
				end else begin
					state_nx = sfs_pkg::ST_DONE;
				end
			end
			sfs_pkg::ST_SEEK_WAIT: begin
				if (!stat.div_busy) state_nx = sfs_pkg::ST_DONE;
			end
			sfs_pkg::ST_TICK_START: state_nx = sfs_pkg::ST_FRAME_RD;
			sfs_pkg::ST_FRAME_RD:   state_nx = sfs_pkg::ST_FRAME_CHK;
			sfs_pkg::ST_FRAME_CHK: begin
				if (stat.e_le_d) begin
					state_nx = sfs_pkg::ST_CELL_RD;
				end else if (stat.need_reduce) begin
					state_nx = sfs_pkg::ST_SUM;
				end else if (stat.adv_stop) begin
					state_nx = sfs_pkg::ST_CELL_RD;
				end else begin
					state_nx = sfs_pkg::ST_FRAME_RD;
				end
			end
			sfs_pkg::ST_SUM: begin
				if (stat.sum_last) state_nx = sfs_pkg::ST_SUM_TAIL;
			end
			sfs_pkg::ST_SUM_TAIL: state_nx = sfs_pkg::ST_MOD_CHK;
			sfs_pkg::ST_MOD_CHK: begin
				state_nx = stat.e_gt_total ? sfs_pkg::ST_MOD_WAIT : sfs_pkg::ST_FRAME_RD;
			end
			sfs_pkg::ST_MOD_WAIT: begin
				if (!stat.div_busy) state_nx = sfs_pkg::ST_FRAME_RD;
			end
			sfs_pkg::ST_CELL_RD:  state_nx = sfs_pkg::ST_LIN;
			sfs_pkg::ST_LIN:      state_nx = sfs_pkg::ST_RECT_DIV;
			sfs_pkg::ST_RECT_DIV: state_nx = sfs_pkg::ST_RECT_WAIT;
			sfs_pkg::ST_RECT_WAIT: begin
				if (!stat.div_busy) state_nx = sfs_pkg::ST_TOP;
			end
			sfs_pkg::ST_TOP:      state_nx = sfs_pkg::ST_RECT_FIN;
			sfs_pkg::ST_RECT_FIN: state_nx = sfs_pkg::ST_DONE;
			sfs_pkg::ST_DONE: begin
				if (out_free) state_nx = sfs_pkg::ST_IDLE;
			end
			default: state_nx = sfs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			sfs_pkg::ST_IDLE: cmd.latch_in = accept;
			sfs_pkg::ST_DECODE: begin
				if (stat.op == sfs_pkg::OP_SEEK) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = sfs_pkg::DIV_SEEK;
				end else if (!(stat.op == sfs_pkg::OP_TICK && stat.playing)) begin
					cmd.do_simple = 1'b1;
				end
			end
			sfs_pkg::ST_SEEK_WAIT:  cmd.seek_apply = !stat.div_busy;
			sfs_pkg::ST_TICK_START: cmd.tick_start = 1'b1;
			sfs_pkg::ST_FRAME_RD:   cmd.rd_en = 1'b1;
			sfs_pkg::ST_FRAME_CHK: begin
				if (!stat.e_le_d) begin
					if (stat.need_reduce) begin
						cmd.sum_clear = 1'b1;
					end else begin
						cmd.advance = 1'b1;
					end
				end
			end
			sfs_pkg::ST_SUM: begin
				cmd.sum_issue = 1'b1;
				cmd.rd_en     = 1'b1;
				cmd.rd_sum    = 1'b1;
			end
			sfs_pkg::ST_MOD_CHK: begin
				cmd.div_start = stat.e_gt_total;
				cmd.div_sel   = sfs_pkg::DIV_MOD;
			end
			sfs_pkg::ST_MOD_WAIT: cmd.mod_apply = !stat.div_busy;
			sfs_pkg::ST_CELL_RD:  cmd.rd_en = 1'b1;
			sfs_pkg::ST_LIN:      cmd.lin_load = 1'b1;
			sfs_pkg::ST_RECT_DIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = sfs_pkg::DIV_RECT;
			end
			sfs_pkg::ST_TOP:      cmd.top_load = 1'b1;
			sfs_pkg::ST_RECT_FIN: cmd.rect_load = 1'b1;
			sfs_pkg::ST_DONE:     cmd.out_load = out_free;
			default: ;
		endcase
	end

	assign item_ready   = state_q == sfs_pkg::ST_IDLE;
	assign result_valid = out_valid_q;

endmodule

`default_nettype wire

// File: rtl/core/sprite_frame_sequencer_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake               Payload                  Beat
// item      item_valid/item_ready   item (sfs_pkg::item_t)   one command
// result    result_valid/result_ready result (result_t)      one per item
// cfg       cfg_valid/cfg_ready     cfg_index, cfg_data      one register write
//
// One item at a time. Play, pause, stop, load and ignored ticks go from decode straight to done.
// Seek waits on the shared 32-step serial divider.
// Playing tick: frames are read and advanced one by one; at frame zero with looping on, the
// durations are summed and the divider takes whole loops off when the elapsed time covers one;
// the divider then also finds the cell's place on the sheet.
// Reset clears the control and sequencer state (slot store through per-slot valid bits).
// A waiting result does not stop the next item from being accepted.
module sprite_frame_sequencer_unit #(
	parameter int MAX_FRAMES = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           item_valid,
	output logic                                item_ready,
	input  wire sfs_pkg::item_t                 item,
	output logic                                result_valid,
	input  wire logic                           result_ready,
	output sfs_pkg::result_t                    result,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [sfs_pkg::CIDX_W-1:0]     cfg_index,
	input  wire logic [sfs_pkg::COORD_W-1:0]    cfg_data
);

	sfs_pkg::cfg_t  cfg_q;
	sfs_pkg::cmd_t  cmd;
	sfs_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sheet_span  <= sfs_pkg::COORD_W'(1);
			cfg_q.origin_x    <= '0;
			cfg_q.origin_y    <= '0;
			cfg_q.step_x      <= sfs_pkg::COORD_W'(1);
			cfg_q.step_y      <= '0;
			cfg_q.frame_count <= sfs_pkg::FC_W'(1);
			cfg_q.loop_enable <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				sfs_pkg::CFG_SHEET_SPAN:  cfg_q.sheet_span  <= cfg_data;
				sfs_pkg::CFG_ORIGIN_X:    cfg_q.origin_x    <= cfg_data;
				sfs_pkg::CFG_ORIGIN_Y:    cfg_q.origin_y    <= cfg_data;
				sfs_pkg::CFG_STEP_X:      cfg_q.step_x      <= cfg_data;
				sfs_pkg::CFG_STEP_Y:      cfg_q.step_y      <= cfg_data;
				sfs_pkg::CFG_FRAME_COUNT: cfg_q.frame_count <= cfg_data[sfs_pkg::FC_W-1:0];
				sfs_pkg::CFG_LOOP_ENABLE: cfg_q.loop_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	sfs_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.stat        (stat),
		.cmd         (cmd)
	);

	sfs_datapath #(
		.MAX_FRAMES(MAX_FRAMES)
	) u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_q),
		.item  (item),
		.cmd   (cmd),
		.stat  (stat),
		.result(result)
	);

endmodule

`default_nettype wire

// File: rtl/core/sfs_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sfs_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             item_valid,
	input wire logic             item_ready,
	input wire logic             result_valid,
	input wire logic             result_ready,
	input wire sfs_pkg::result_t result
);

	// a held result beat does not change
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// only one item in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("second item taken while one is in work");

	// a new result only appears after the block was busy with an item
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !$past(item_ready))
		else $error("result raised without work");

	// checked in the cycle after reset is seen, so the asynchronous clear has settled
	a_reset_state: assert property (@(posedge clk)
		!arst_n |=> !result_valid && item_ready)
		else $error("bad state in reset");

endmodule

bind sprite_frame_sequencer_unit sfs_checker u_sfs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_ready  (item_ready),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result      (result)
);

`default_nettype wire

// File: test/tb_sprite_frame_sequencer_unit.sv
`timescale 1ns / 1ps

module tb_sprite_frame_sequencer_unit;
	import sfs_pkg::*;

	localparam int SLOTS = 16;
	// operation codes the block decodes as no-ops
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;

	typedef struct packed {
		logic              is_cfg;
		logic [CIDX_W-1:0] reg_idx;
		logic [15:0]       reg_val;
		item_t             cmd;
		logic              typed;
		result_t           want;
	} plan_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                item_valid = 1'b0;
	logic                item_ready;
	item_t               item = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	result_t             result;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CIDX_W-1:0]   cfg_index = '0;
	logic [COORD_W-1:0]  cfg_data = '0;

	// shadow of the register file
	logic [15:0] sh_span = 16'd1;
	logic [15:0] sh_ox = 16'd0;
	logic [15:0] sh_oy = 16'd0;
	logic [15:0] sh_sx = 16'd1;
	logic [15:0] sh_sy = 16'd0;
	logic [4:0]  sh_fc = 5'd1;
	logic        sh_loop = 1'b1;

	// sequencer state as the block should hold it
	logic [31:0] seq_elapsed = '0;
	int          seq_frame = 0;
	logic [1:0]  seq_run = PS_PLAYING;
	logic [31:0] slot_dur [SLOTS] = '{default: '0};
	logic [11:0] slot_cell [SLOTS] = '{default: '0};
	logic [15:0] seq_left = '0;
	logic [15:0] seq_top = '0;

	result_t     frame_results [$];
	plan_row_t   plan [$];
	int          mismatches = 0;
	int          gap_pct = 0;
	int          stall_pct = 0;
	int          hold_left = 0;
	bit          hold_request = 1'b0;

	sprite_frame_sequencer_unit #(.MAX_FRAMES(SLOTS)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic int frames_in_use();
		if (sh_fc == 0) return 1;
		if (sh_fc > SLOTS) return SLOTS;
		return sh_fc;
	endfunction

	function automatic longint unsigned hold_time(input int idx);
		return (slot_dur[idx] == 0) ? 64'd1 : 64'(slot_dur[idx]);
	endfunction

	function automatic result_t apply_command(input item_t cmd);
		longint unsigned e, lap, lin, span, l, t;
		int cnt, k;
		bit folded;
		result_t r;
		case (cmd.operation)
			OP_TICK: if (seq_run == PS_PLAYING) begin
				cnt = frames_in_use();
				if (seq_frame >= cnt) seq_frame = 0;
				e = seq_elapsed;
				e = e + cmd.delta;
				if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
				folded = 1'b0;
				while (e > hold_time(seq_frame)) begin
					// whole loops come off in one go, once per tick
					if (seq_frame == 0 && sh_loop && !folded) begin
						lap = 0;
						for (k = 0; k < cnt; k++) lap += hold_time(k);
						if (e > lap) e -= ((e - 1) / lap) * lap;
						folded = 1'b1;
						if (e <= hold_time(seq_frame)) break;
					end
					e -= hold_time(seq_frame);
					if (seq_frame + 1 >= cnt) begin
						if (sh_loop) begin
							seq_frame = 0;
						end else begin
							seq_frame = cnt - 1;
							seq_run = PS_STOPPED;
							break;
						end
					end else begin
						seq_frame++;
					end
				end
				seq_elapsed = e[31:0];
				span = (sh_span == 0) ? 64'd1 : 64'(sh_span);
				lin = slot_cell[seq_frame];
				lin = lin * sh_sx;
				l = lin % span + sh_ox;
				t = lin / span;
				t = t * sh_sy + sh_oy;
				seq_left = (l > 65535) ? 16'hFFFF : l[15:0];
				seq_top = (t > 65535) ? 16'hFFFF : t[15:0];
			end
			OP_PLAY: seq_run = PS_PLAYING;
			OP_PAUSE: seq_run = PS_PAUSED;
			OP_STOP: begin
				seq_run = PS_STOPPED;
				seq_frame = 0;
			end
			OP_SEEK: begin
				seq_frame = cmd.slot % frames_in_use();
				seq_elapsed = '0;
			end
			OP_LOAD: if (cmd.slot < SLOTS) begin
				slot_dur[cmd.slot] = cmd.duration;
				slot_cell[cmd.slot] = cmd.cell_req;
			end
			default: ;
		endcase
		r.left = seq_left;
		r.top = seq_top;
		r.frame_now = seq_frame[3:0];
		r.play_status = seq_run;
		return r;
	endfunction

	function automatic logic [31:0] pick_time(input int unsigned typical);
		case ($urandom_range(9))
			8: return $urandom();
			9: return 32'hFFFF_FFFF;
			6, 7: return $urandom_range(typical * 10);
			default: return $urandom_range(typical);
		endcase
	endfunction

	function automatic logic [15:0] coord_value();
		case ($urandom_range(5))
			0: return 16'd0;
			1: return 16'hFFFF;
			2, 3: return 16'($urandom_range(64, 1));
			default: return 16'($urandom_range(65535));
		endcase
	endfunction

	function automatic item_t random_command();
		item_t c;
		int pick;
		pick = $urandom_range(99);
		if (pick < 42) c.operation = OP_TICK;
		else if (pick < 62) c.operation = OP_LOAD;
		else if (pick < 72) c.operation = OP_SEEK;
		else if (pick < 84) c.operation = OP_PLAY;
		else if (pick < 89) c.operation = OP_PAUSE;
		else if (pick < 94) c.operation = OP_STOP;
		else c.operation = pick[0] ? OP_SPARE7 : OP_SPARE6;
		c.delta = pick_time(40);
		c.duration = pick_time(12);
		c.slot = ($urandom_range(9) < 7) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
		c.cell_req = 12'($urandom_range(4095));
		return c;
	endfunction

	task automatic push_item(input item_t cmd, input bit typed, input result_t want);
		result_t guess;
		while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= cmd;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		guess = apply_command(cmd);
		frame_results.push_back(typed ? want : guess);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_SHEET_SPAN: sh_span = val;
			CFG_ORIGIN_X: sh_ox = val;
			CFG_ORIGIN_Y: sh_oy = val;
			CFG_STEP_X: sh_sx = val;
			CFG_STEP_Y: sh_sy = val;
			CFG_FRAME_COUNT: sh_fc = val[4:0];
			CFG_LOOP_ENABLE: sh_loop = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (frame_results.size() != 0) @(posedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic program_setup(input int ph);
		logic [15:0] span, ox, oy, sx, sy;
		logic [4:0] fc;
		logic lp;
		if (ph == 0) begin
			span = 16'd1; ox = 16'd0; oy = 16'd0; sx = 16'd1; sy = 16'd0;
			fc = 5'd1; lp = 1'b0;
		end else if (ph == 1) begin
			span = '1; ox = '1; oy = '1; sx = '1; sy = '1;
			fc = 5'd16; lp = 1'b1;
		end else begin
			span = coord_value();
			ox = coord_value();
			oy = coord_value();
			sx = coord_value();
			sy = coord_value();
			fc = ($urandom_range(7) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16, 1));
			lp = 1'($urandom_range(1));
		end
		write_reg(CFG_SHEET_SPAN, span);
		write_reg(CFG_ORIGIN_X, ox);
		write_reg(CFG_ORIGIN_Y, oy);
		write_reg(CFG_STEP_X, sx);
		write_reg(CFG_STEP_Y, sy);
		write_reg(CFG_FRAME_COUNT, 16'(fc));
		write_reg(CFG_LOOP_ENABLE, 16'(lp));
	endtask

	// receiver: random stalls plus an occasional long hold-off
	always @(negedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = 400;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic compare_field(input string what, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (result_valid === 1'b1 && result_ready) begin
			if (frame_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected beat, expected none, actual %p", $time, result);
			end else begin
				want = frame_results.pop_front();
				compare_field("left", want.left, result.left);
				compare_field("top", want.top, result.top);
				compare_field("frame_now", 16'(want.frame_now), 16'(result.frame_now));
				compare_field("play_status", 16'(want.play_status), 16'(result.play_status));
			end
		end
	end

	initial begin
		plan_row_t row;
		int ph, n;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		plan = '{
			// reset defaults: one frame, looping, unit pitch, empty slots
			'{0, '0, '0, '{OP_PLAY, 0, 0, 0, 0}, 1, '{0, 0, 0, PS_PLAYING}},
			'{0, '0, '0, '{OP_PAUSE, 0, 0, 0, 0}, 1, '{0, 0, 0, PS_PAUSED}},
			'{0, '0, '0, '{OP_SPARE6, '1, '1, '1, '1}, 1, '{0, 0, 0, PS_PAUSED}},
			'{0, '0, '0, '{OP_TICK, '1, 0, 0, 0}, 1, '{0, 0, 0, PS_PAUSED}},
			'{0, '0, '0, '{OP_LOAD, 0, '1, '1, '1}, 1, '{0, 0, 0, PS_PAUSED}},
			'{0, '0, '0, '{OP_SPARE7, 0, 0, 0, 0}, 1, '{0, 0, 0, PS_PAUSED}},
			'{0, '0, '0, '{OP_STOP, 0, 0, 0, 0}, 1, '{0, 0, 0, PS_STOPPED}},
			'{0, '0, '0, '{OP_PLAY, 0, 0, 0, 0}, 1, '{0, 0, 0, PS_PLAYING}},
			'{0, '0, '0, '{OP_TICK, '1, 0, 0, 0}, 1, '{0, 0, 0, PS_PLAYING}},
			// four frames, coordinates pushed into saturation
			'{1, CFG_SHEET_SPAN, 100, '0, 0, '0},
			'{1, CFG_ORIGIN_X, 16'hFFFF, '0, 0, '0},
			'{1, CFG_ORIGIN_Y, 3, '0, 0, '0},
			'{1, CFG_STEP_X, 16'hFFFF, '0, 0, '0},
			'{1, CFG_STEP_Y, 16'hFFFF, '0, 0, '0},
			'{1, CFG_FRAME_COUNT, 4, '0, 0, '0},
			'{1, CFG_LOOP_ENABLE, 1, '0, 0, '0},
			'{0, '0, '0, '{OP_LOAD, 0, 0, 0, '1}, 0, '0},
			'{0, '0, '0, '{OP_LOAD, 0, 1, '1, 0}, 0, '0},
			'{0, '0, '0, '{OP_LOAD, 0, 2, 5, 1}, 0, '0},
			'{0, '0, '0, '{OP_LOAD, 0, 3, 10, 7}, 0, '0},
			'{0, '0, '0, '{OP_TICK, 3, 0, 0, 0}, 0, '0},
			'{0, '0, '0, '{OP_SEEK, 0, 2, 0, 0}, 0, '0},
			'{0, '0, '0, '{OP_TICK, 6, 0, 0, 0}, 0, '0},
			'{0, '0, '0, '{OP_TICK, '1, 0, 0, 0}, 0, '0},
			'{0, '0, '0, '{OP_SEEK, 0, 3, 0, 0}, 0, '0},
			// count lowered below the current frame, no looping
			'{1, CFG_FRAME_COUNT, 2, '0, 0, '0},
			'{1, CFG_LOOP_ENABLE, 0, '0, 0, '0},
			'{0, '0, '0, '{OP_LOAD, 0, 1, 2, 3}, 0, '0},
			'{0, '0, '0, '{OP_TICK, 50, 0, 0, 0}, 0, '0},
			// zero count, zero span, zero pitch
			'{1, CFG_FRAME_COUNT, 0, '0, 0, '0},
			'{1, CFG_SHEET_SPAN, 0, '0, 0, '0},
			'{1, CFG_ORIGIN_Y, 16'hFFFF, '0, 0, '0},
			'{1, CFG_STEP_X, 0, '0, 0, '0},
			'{1, CFG_LOOP_ENABLE, 1, '0, 0, '0},
			'{0, '0, '0, '{OP_PLAY, 0, 0, 0, 0}, 0, '0},
			'{0, '0, '0, '{OP_TICK, 1, 0, 0, 0}, 0, '0},
			// count above the slot store
			'{1, CFG_FRAME_COUNT, 31, '0, 0, '0},
			'{1, CFG_SHEET_SPAN, 16'hFFFF, '0, 0, '0},
			'{1, CFG_ORIGIN_X, 0, '0, 0, '0},
			'{1, CFG_ORIGIN_Y, 0, '0, 0, '0},
			'{1, CFG_STEP_X, 1, '0, 0, '0},
			'{1, CFG_STEP_Y, 0, '0, 0, '0},
			'{0, '0, '0, '{OP_SEEK, 0, '1, 0, 0}, 0, '0},
			'{0, '0, '0, '{OP_TICK, '1, 0, 0, 0}, 0, '0}
		};

		foreach (plan[i]) begin
			row = plan[i];
			if (row.is_cfg) begin
				drain();
				write_reg(row.reg_idx, row.reg_val);
			end else begin
				push_item(row.cmd, row.typed, row.want);
			end
		end

		for (ph = 0; ph < 8; ph++) begin
			drain();
			case (ph % 4)
				0: begin gap_pct = 0; stall_pct = 0; end
				1: begin gap_pct = 62; stall_pct = 0; end
				2: begin gap_pct = 0; stall_pct = 62; end
				default: begin gap_pct = 31; stall_pct = 31; end
			endcase
			program_setup(ph);
			for (n = 0; n < 220; n++) begin
				// long receiver hold-off: the block backs up and stalls its input
				if (ph == 2 && n == 60) hold_request = 1'b1;
				// sender waits once for every outstanding beat before going on
				if (ph == 5 && n == 110) drain();
				push_item(random_command(), 1'b0, '0);
			end
		end

		item_valid <= 1'b0;
		while (frame_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule
